>>> rtl/core/hsvc_pkg.sv
package hsvc_pkg;

  // fixed-point constants
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SECTOR_W   = 3;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
  // 255 * 65536, full scale in q16
  localparam logic [23:0] FULL_SCALE_Q16 = 24'd16711680;

  // register addresses
  localparam logic [CFG_ADDR_W-1:0] ADDR_GRAY_TO_WHITE = 2'd0;

  // sector codes
  localparam logic [SECTOR_W-1:0] SECT_RED_RISE_GREEN = 3'd0;
  localparam logic [SECTOR_W-1:0] SECT_FALL_RED       = 3'd1;
  localparam logic [SECTOR_W-1:0] SECT_RISE_BLUE      = 3'd2;
  localparam logic [SECTOR_W-1:0] SECT_FALL_GREEN     = 3'd3;
  localparam logic [SECTOR_W-1:0] SECT_RISE_RED       = 3'd4;

  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  value_level;
    logic        pixel_on;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] white_out;
  } out_pixel_t;

  // channel levels handed from the arithmetic pipe to the output mux
  typedef struct packed {
    logic                valid;
    logic                gray;
    logic                pixel_on;
    logic [SECTOR_W-1:0] sector;
    logic [CHAN_W-1:0]   v;
    logic [CHAN_W-1:0]   p;
    logic [CHAN_W-1:0]   q;
    logic [CHAN_W-1:0]   t;
  } hsvc_levels_t;

  // floor(x / 255) for x <= 65279: reciprocal estimate, then one correction
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    logic [8:0]  q0;
    logic [16:0] back;
    logic [16:0] rem;
    logic [8:0]  q1;
    sum  = {1'b0, x} + {9'b0, x[15:8]};
    q0   = sum[16:8];
    back = {q0, 8'b0} - {8'b0, q0};
    rem  = {1'b0, x} - back;
    q1   = (rem >= 17'd255) ? q0 + 9'd1 : q0;
    return q1[CHAN_W-1:0];
  endfunction

endpackage

>>> rtl/core/hsvc_cfg.sv
module hsvc_cfg
  import hsvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  gray_to_white
);

  logic gray_to_white_r;

  assign pready        = 1'b1;
  assign gray_to_white = gray_to_white_r;

  // register write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_to_white_r <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == ADDR_GRAY_TO_WHITE)) begin
      gray_to_white_r <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_GRAY_TO_WHITE) begin
      prdata[0] = gray_to_white_r;
    end
  end

endmodule

>>> rtl/core/hsvc_arith.sv
module hsvc_arith
  import hsvc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  in_pixel_t    in_pixel,
  input  logic         gray_to_white,
  output hsvc_levels_t levels
);

  // stage 1: sector split and p product
  logic                s1_valid_r;
  logic                s1_gray_r;
  logic                s1_on_r;
  logic [SECTOR_W-1:0] s1_sector_r;
  logic [FRAC_W-1:0]   s1_frac_r;
  logic [CHAN_W-1:0]   s1_sat_r;
  logic [CHAN_W-1:0]   s1_val_r;
  logic [15:0]         s1_pprod_r;
  logic [18:0]         h6;

  assign h6 = ({3'b0, in_pixel.hue} << 2) + ({3'b0, in_pixel.hue} << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_gray_r   <= gray_to_white && (in_pixel.saturation == '0);
    s1_on_r     <= in_pixel.pixel_on;
    s1_sector_r <= h6[18:16];
    s1_frac_r   <= h6[15:0];
    s1_sat_r    <= in_pixel.saturation;
    s1_val_r    <= in_pixel.value_level;
    s1_pprod_r  <= {8'b0, in_pixel.value_level} * {8'b0, FULL_SCALE - in_pixel.saturation};
  end

  // stage 2: f * s product, p divided down
  logic                s2_valid_r;
  logic                s2_gray_r;
  logic                s2_on_r;
  logic [SECTOR_W-1:0] s2_sector_r;
  logic [CHAN_W-1:0]   s2_sat_r;
  logic [CHAN_W-1:0]   s2_val_r;
  logic [CHAN_W-1:0]   s2_p_r;
  logic [23:0]         s2_fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_gray_r   <= s1_gray_r;
    s2_on_r     <= s1_on_r;
    s2_sector_r <= s1_sector_r;
    s2_sat_r    <= s1_sat_r;
    s2_val_r    <= s1_val_r;
    s2_p_r      <= div255(s1_pprod_r);
    s2_fs_r     <= {8'b0, s1_frac_r} * {16'b0, s1_sat_r};
  end

  // stage 3: q and t numerators scaled by v, q16 fraction dropped
  logic                s3_valid_r;
  logic                s3_gray_r;
  logic                s3_on_r;
  logic [SECTOR_W-1:0] s3_sector_r;
  logic [CHAN_W-1:0]   s3_val_r;
  logic [CHAN_W-1:0]   s3_p_r;
  logic [15:0]         s3_qy_r;
  logic [15:0]         s3_ty_r;
  logic [23:0]         q_num;
  logic [23:0]         t_num;
  logic [31:0]         q_prod;
  logic [31:0]         t_prod;

  assign q_num  = FULL_SCALE_Q16 - s2_fs_r;
  assign t_num  = FULL_SCALE_Q16 - {s2_sat_r, 16'b0} + s2_fs_r;
  assign q_prod = {24'b0, s2_val_r} * {8'b0, q_num};
  assign t_prod = {24'b0, s2_val_r} * {8'b0, t_num};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_gray_r   <= s2_gray_r;
    s3_on_r     <= s2_on_r;
    s3_sector_r <= s2_sector_r;
    s3_val_r    <= s2_val_r;
    s3_p_r      <= s2_p_r;
    s3_qy_r     <= q_prod[31:16];
    s3_ty_r     <= t_prod[31:16];
  end

  // stage 4: q and t divided down
  hsvc_levels_t s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid <= 1'b0;
    end else begin
      s4_r.valid <= s3_valid_r;
    end
    s4_r.gray     <= s3_gray_r;
    s4_r.pixel_on <= s3_on_r;
    s4_r.sector   <= s3_sector_r;
    s4_r.v        <= s3_val_r;
    s4_r.p        <= s3_p_r;
    s4_r.q        <= div255(s3_qy_r);
    s4_r.t        <= div255(s3_ty_r);
  end

  assign levels = s4_r;

endmodule

>>> rtl/core/hsvc_mux.sv
module hsvc_mux
  import hsvc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  hsvc_levels_t levels,
  output logic         out_strobe,
  output out_pixel_t   out_pixel
);

  logic       strobe_r;
  out_pixel_t pix_r;
  out_pixel_t pix_nxt;

  // sector routing, gate and gray-to-white override
  always_comb begin
    pix_nxt = '0;
    if (levels.gray) begin
      pix_nxt.white_out = levels.v;
    end else begin
      unique case (levels.sector)
        SECT_RED_RISE_GREEN: begin
          pix_nxt.red_out   = levels.v;
          pix_nxt.green_out = levels.t;
          pix_nxt.blue_out  = levels.p;
        end
        SECT_FALL_RED: begin
          pix_nxt.red_out   = levels.q;
          pix_nxt.green_out = levels.v;
          pix_nxt.blue_out  = levels.p;
        end
        SECT_RISE_BLUE: begin
          pix_nxt.red_out   = levels.p;
          pix_nxt.green_out = levels.v;
          pix_nxt.blue_out  = levels.t;
        end
        SECT_FALL_GREEN: begin
          pix_nxt.red_out   = levels.p;
          pix_nxt.green_out = levels.q;
          pix_nxt.blue_out  = levels.v;
        end
        SECT_RISE_RED: begin
          pix_nxt.red_out   = levels.t;
          pix_nxt.green_out = levels.p;
          pix_nxt.blue_out  = levels.v;
        end
        default: begin
          pix_nxt.red_out   = levels.v;
          pix_nxt.green_out = levels.p;
          pix_nxt.blue_out  = levels.q;
        end
      endcase
      if (!levels.pixel_on) begin
        pix_nxt.red_out   = '0;
        pix_nxt.green_out = '0;
        pix_nxt.blue_out  = '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= levels.valid;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_pixel  = pix_r;

endmodule

>>> rtl/core/hsv_to_rgbw_pixel_colorizer_top.sv
// hsv to rgbw pixel colouriser: one pixel beat is taken every clock (busy is
// never raised) and its red, green, blue and white bytes appear on out_pixel
// with out_strobe high for one cycle. The pipe has five register stages
// (sector split, p divide, q/t multiplies, q/t divides, channel select);
// results cannot be held off, so the receiver must take every beat as it
// comes. The gray_to_white register sits at byte address 0 and should only
// be written while no pixel is in flight.
module hsv_to_rgbw_pixel_colorizer_top
  import hsvc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_pixel_t             in_pixel,
  output logic                  out_strobe,
  output out_pixel_t            out_pixel,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic         gray_to_white;
  hsvc_levels_t levels;

  // pipe never stalls
  assign busy = 1'b0;

  hsvc_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .gray_to_white (gray_to_white)
  );

  hsvc_arith u_arith (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start && !busy),
    .in_pixel      (in_pixel),
    .gray_to_white (gray_to_white),
    .levels        (levels)
  );

  hsvc_mux u_mux (
    .clk        (clk),
    .rst_n      (rst_n),
    .levels     (levels),
    .out_strobe (out_strobe),
    .out_pixel  (out_pixel)
  );

endmodule
